// ===== rtl/brl_pkg.sv =====
package brl_pkg;

  // Every coordinate field on both channels is this wide.
  localparam int unsigned CoordW = 6;

  // Error term width: it stays within about twice the largest delta.
  localparam int unsigned ErrW = CoordW + 3;

  localparam int unsigned InDataW  = 4 * CoordW;
  localparam int unsigned OutDataW = ((2 * CoordW + 7) / 8) * 8;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic signed [ErrW-1:0] err_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // take a new line command
    logic emit;  // move the current pixel to the output register and step
  } brl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;  // the current pixel is the line's end point
  } brl_stat_t;

endpackage

// ===== rtl/brl_datapath.sv =====
module brl_datapath import brl_pkg::*; #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  brl_cmd_t       cmd_i,
  output brl_stat_t      stat_o,
  input  coord_t         x_start_i,
  input  coord_t         y_start_i,
  input  coord_t         x_end_i,
  input  coord_t         y_end_i,
  output coord_t         pixel_x_o,
  output coord_t         pixel_y_o,
  output logic           last_o
);

  localparam coord_t CoordMax = coord_t'(GRID_SIZE - 1);

  coord_t cx_q, cx_d, cy_q, cy_d, ex_q, ey_q, dx_q, dy_q;
  logic   sx_q, sy_q;
  err_t   err_q, err_d;
  coord_t px_q, py_q;
  logic   last_q;

  coord_t in_cx, in_cy, in_ex, in_ey;
  coord_t in_dx, in_dy;
  logic   done;
  logic signed [ErrW:0] e2, dx_s, dy_s;
  logic   step_x, step_y;

  function automatic coord_t clamp(coord_t v);
    return (v > CoordMax) ? CoordMax : v;
  endfunction

  assign in_cx = clamp(x_start_i);
  assign in_cy = clamp(y_start_i);
  assign in_ex = clamp(x_end_i);
  assign in_ey = clamp(y_end_i);
  assign in_dx = (in_ex > in_cx) ? (in_ex - in_cx) : (in_cx - in_ex);
  assign in_dy = (in_ey > in_cy) ? (in_ey - in_cy) : (in_cy - in_ey);

  assign done = (cx_q == ex_q) && (cy_q == ey_q);
  assign stat_o.done = done;

  assign dx_s   = $signed({{(ErrW + 1 - CoordW){1'b0}}, dx_q});
  assign dy_s   = $signed({{(ErrW + 1 - CoordW){1'b0}}, dy_q});
  assign e2     = $signed({err_q, 1'b0});
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;

  always_comb begin
    err_d = err_q;
    cx_d  = cx_q;
    cy_d  = cy_q;
    if (step_x) begin
      err_d = err_d - $signed({{(ErrW - CoordW){1'b0}}, dy_q});
      cx_d  = sx_q ? cx_q + coord_t'(1) : cx_q - coord_t'(1);
    end
    if (step_y) begin
      err_d = err_d + $signed({{(ErrW - CoordW){1'b0}}, dx_q});
      cy_d  = sy_q ? cy_q + coord_t'(1) : cy_q - coord_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q  <= in_cx;
      cy_q  <= in_cy;
      ex_q  <= in_ex;
      ey_q  <= in_ey;
      dx_q  <= in_dx;
      dy_q  <= in_dy;
      sx_q  <= in_cx < in_ex;
      sy_q  <= in_cy < in_ey;
      err_q <= $signed({{(ErrW - CoordW){1'b0}}, in_dx})
             - $signed({{(ErrW - CoordW){1'b0}}, in_dy});
    end else if (cmd_i.emit) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      px_q   <= cx_q;
      py_q   <= cy_q;
      last_q <= done;
    end
  end

  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;
  assign last_o    = last_q;

  // Away from the end point every step must move at least one axis.
  a_step_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !done) |-> (step_x || step_y))
    else $error("walk step moved neither axis");

endmodule

// ===== rtl/brl_ctrl.sv =====
module brl_ctrl import brl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output brl_cmd_t  cmd_o,
  input  brl_stat_t stat_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (stat_i.done) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && stat_i.done) |=> (state_q == StIdle))
    else $error("controller kept walking after the end point");

  a_load_to_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StWalk && !in_ready_o))
    else $error("controller did not start a walk after a load");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_o)
    else $error("emitted pixel not presented on the output");

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer: one line command in, every pixel of the line out.
// Each command is loaded into the walk registers, then each pixel moves into the
// output register; one pixel per cycle unless downstream stalls. A line has
// N = max(dx,dy)+1 pixels, at most GRID_SIZE.
// Reset: rst_ni is asynchronous and active low; it empties the output register
// and returns the controller to idle. No other state needs clearing.
module bresenham_line_rasterizer import brl_pkg::*; #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata fields from bit 0: x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18].
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata fields from bit 0: pixel_x[5:0], pixel_y[11:6], zero padding above.
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // tlast marks the line's end point.
  output logic                m_axis_tlast_o
);

  // The controller owns the handshakes and the walk state; the datapath holds
  // the current pixel, the deltas, the step directions and the error term,
  // plus the output register that decouples the walk from downstream stalls.
  // A new command is taken as soon as the end point has moved into the output
  // register, even while that final pixel is still waiting to be taken.

  brl_cmd_t  cmd;
  brl_stat_t stat;
  coord_t    pixel_x, pixel_y;

  brl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Coordinates beyond the grid are saturated to its last row or column
  // inside the datapath when the command is loaded.
  brl_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .x_start_i (s_axis_tdata_i[CoordW-1:0]),
    .y_start_i (s_axis_tdata_i[2*CoordW-1:CoordW]),
    .x_end_i   (s_axis_tdata_i[3*CoordW-1:2*CoordW]),
    .y_end_i   (s_axis_tdata_i[4*CoordW-1:3*CoordW]),
    .pixel_x_o (pixel_x),
    .pixel_y_o (pixel_y),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OutDataW - 2 * CoordW){1'b0}}, pixel_y, pixel_x};

endmodule
